// ----- design/spsu_pkg.sv -----
package spsu_pkg;

    // Parser position within the PDU
    typedef enum logic [3:0] {
        PH_FLAGS,
        PH_REF,
        PH_ALEN,
        PH_TYPE,
        PH_ADDR,
        PH_PID,
        PH_DCS,
        PH_UDL,
        PH_DATA,
        PH_DONE
    } t_phase;

    // Result item tags
    typedef enum logic [2:0] {
        K_ALEN  = 3'd0,
        K_DIGIT = 3'd1,
        K_FMT   = 3'd2,
        K_CHAR  = 3'd3,
        K_END   = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] value;
        logic       last;
    } t_result;

    localparam int MAX_RESULTS = 3;

    // Results made by one octet, in delivery order; count is 0..MAX_RESULTS
    typedef struct packed {
        logic [1:0]                       count;
        t_result [MAX_RESULTS-1:0]        items;
    } t_result_group;

    localparam int RQ_DEPTH = 8;
    localparam int RQ_AW    = 3;

    localparam logic [7:0] HDR_FLAG_MASK = 8'h40;
    localparam logic [3:0] FILLER_NIBBLE = 4'hF;

    // floor(x / 7) == (x * SKIP_RECIP) >> SKIP_RECIP_SHIFT for x below 5461
    localparam logic [11:0] SKIP_RECIP       = 12'd2341;
    localparam int          SKIP_RECIP_SHIFT = 14;

    // Header skip in 7-bit mode: ceil((c + 1) * 8 / 7)
    function automatic logic [8:0] septet_skip(input logic [6:0] c);
        logic [7:0]  c1;
        logic [10:0] x;
        logic [22:0] p;
        c1 = {1'b0, c} + 8'd1;
        x  = {c1, 3'b000} + 11'd6;
        p  = x * SKIP_RECIP;
        return p[SKIP_RECIP_SHIFT +: 9];
    endfunction

endpackage

// ----- design/spsu_parser.sv -----
module spsu_parser
    import spsu_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_take,
    input  logic [7:0]    i_octet,
    input  logic          i_pdu_start,
    output t_result_group o_group
);

    typedef struct packed {
        logic       emit;
        logic [7:0] produced;
        logic [8:0] skip;
    } t_take;

    // Count one decoded character against the declared length and header skip
    function automatic t_take take_char(
        input logic [7:0] c,
        input logic [7:0] produced,
        input logic [8:0] skip,
        input logic [7:0] decl,
        input logic       header,
        input logic       raw
    );
        t_take t;
        t.emit     = 1'b0;
        t.produced = produced;
        t.skip     = skip;
        if (produced < decl) begin
            if (produced == 8'd0 && header) begin
                t.skip = raw ? ({1'b0, c} + 9'd1) : septet_skip(c[6:0]);
            end
            t.emit     = ({1'b0, produced} >= t.skip);
            t.produced = produced + 8'd1;
        end
        return t;
    endfunction

    t_phase     r_phase,    n_phase,    c_phase;
    logic       r_header,   n_header,   c_header;
    logic [7:0] r_addr,     n_addr,     c_addr;
    logic       r_raw,      n_raw,      c_raw;
    logic [7:0] r_decl,     n_decl,     c_decl;
    logic [7:0] r_oct_left, n_oct_left, c_oct_left;
    logic [2:0] r_shift,    n_shift,    c_shift;
    logic [6:0] r_carry,    n_carry,    c_carry;
    logic [7:0] r_produced, n_produced, c_produced;
    logic [8:0] r_skip,     n_skip,     c_skip;

    always_comb begin
        logic [1:0]  idx;
        logic        final_octet;
        logic [10:0] udl_x7;
        logic [2:0]  lsh;
        logic [3:0]  rsh;
        logic [14:0] wide;
        logic [6:0]  c1;
        logic [7:0]  next_carry;
        logic [7:0]  end_len;
        t_take       t1;
        t_take       t2;

        // A start octet sees the parser as if freshly reset
        c_phase    = i_pdu_start ? PH_FLAGS : r_phase;
        c_header   = i_pdu_start ? 1'b0     : r_header;
        c_addr     = i_pdu_start ? 8'd0     : r_addr;
        c_raw      = i_pdu_start ? 1'b0     : r_raw;
        c_decl     = i_pdu_start ? 8'd0     : r_decl;
        c_oct_left = i_pdu_start ? 8'd0     : r_oct_left;
        c_shift    = i_pdu_start ? 3'd1     : r_shift;
        c_carry    = i_pdu_start ? 7'd0     : r_carry;
        c_produced = i_pdu_start ? 8'd0     : r_produced;
        c_skip     = i_pdu_start ? 9'd0     : r_skip;

        n_phase    = c_phase;
        n_header   = c_header;
        n_addr     = c_addr;
        n_raw      = c_raw;
        n_decl     = c_decl;
        n_oct_left = c_oct_left;
        n_shift    = c_shift;
        n_carry    = c_carry;
        n_produced = c_produced;
        n_skip     = c_skip;

        idx         = 2'd0;
        o_group     = '0;
        final_octet = (c_addr <= 8'd2);
        udl_x7      = {i_octet, 3'b000} - {3'b000, i_octet} + 11'd7;
        lsh         = c_shift - 3'd1;
        rsh         = 4'd8 - {1'b0, c_shift};
        wide        = {7'b0, i_octet} << lsh;
        c1          = wide[6:0] | c_carry;
        next_carry  = i_octet >> rsh;
        t1          = '0;
        t2          = '0;
        end_len     = 8'd0;

        case (c_phase)
            PH_FLAGS: begin
                n_header = |(i_octet & HDR_FLAG_MASK);
                n_phase  = PH_REF;
            end
            PH_REF: begin
                n_phase = PH_ALEN;
            end
            PH_ALEN: begin
                n_addr = i_octet;
                o_group.items[idx] = '{kind: K_ALEN, value: i_octet, last: 1'b0};
                idx     = idx + 2'd1;
                n_phase = PH_TYPE;
            end
            PH_TYPE: begin
                n_phase = (c_addr != 8'd0) ? PH_ADDR : PH_PID;
            end
            PH_ADDR: begin
                o_group.items[idx] = '{kind: K_DIGIT, value: {4'h0, i_octet[3:0]},
                                       last: 1'b0};
                idx = idx + 2'd1;
                // drop the filler nibble of an odd digit count
                if (!(final_octet && i_octet[7:4] == FILLER_NIBBLE)) begin
                    o_group.items[idx] = '{kind: K_DIGIT, value: {4'h0, i_octet[7:4]},
                                           last: 1'b0};
                    idx = idx + 2'd1;
                end
                if (final_octet) begin
                    n_addr  = 8'd0;
                    n_phase = PH_PID;
                end else begin
                    n_addr = c_addr - 8'd2;
                end
            end
            PH_PID: begin
                n_phase = PH_DCS;
            end
            PH_DCS: begin
                n_raw = (i_octet != 8'd0);
                o_group.items[idx] = '{kind: K_FMT, value: n_raw ? i_octet : 8'd1,
                                       last: 1'b0};
                idx     = idx + 2'd1;
                n_phase = PH_UDL;
            end
            PH_UDL: begin
                n_decl     = i_octet;
                n_oct_left = c_raw ? i_octet : udl_x7[10:3];
                n_shift    = 3'd1;
                n_carry    = 7'd0;
                n_produced = 8'd0;
                n_skip     = 9'd0;
                if (n_oct_left == 8'd0) begin
                    o_group.items[idx] = '{kind: K_END, value: 8'd0, last: 1'b1};
                    idx     = idx + 2'd1;
                    n_phase = PH_DONE;
                end else begin
                    n_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                if (c_raw) begin
                    t1 = take_char(i_octet, c_produced, c_skip, c_decl, c_header, c_raw);
                    if (t1.emit) begin
                        o_group.items[idx] = '{kind: K_CHAR, value: i_octet, last: 1'b0};
                        idx = idx + 2'd1;
                    end
                    n_produced = t1.produced;
                    n_skip     = t1.skip;
                end else begin
                    t1 = take_char({1'b0, c1}, c_produced, c_skip, c_decl, c_header,
                                   c_raw);
                    if (t1.emit) begin
                        o_group.items[idx] = '{kind: K_CHAR, value: {1'b0, c1},
                                               last: 1'b0};
                        idx = idx + 2'd1;
                    end
                    n_produced = t1.produced;
                    n_skip     = t1.skip;
                    if (c_shift == 3'd7) begin
                        // seventh octet of a group also completes an eighth septet
                        t2 = take_char({1'b0, next_carry[6:0]}, t1.produced, t1.skip,
                                       c_decl, c_header, c_raw);
                        if (t2.emit) begin
                            o_group.items[idx] = '{kind: K_CHAR,
                                                   value: {1'b0, next_carry[6:0]},
                                                   last: 1'b0};
                            idx = idx + 2'd1;
                        end
                        n_produced = t2.produced;
                        n_skip     = t2.skip;
                        n_carry    = 7'd0;
                        n_shift    = 3'd1;
                    end else begin
                        n_carry = next_carry[6:0];
                        n_shift = c_shift + 3'd1;
                    end
                end
                n_oct_left = c_oct_left - 8'd1;
                if (n_oct_left == 8'd0) begin
                    end_len = ({1'b0, c_decl} > n_skip) ? (c_decl - n_skip[7:0]) : 8'd0;
                    o_group.items[idx] = '{kind: K_END, value: end_len, last: 1'b1};
                    idx     = idx + 2'd1;
                    n_phase = PH_DONE;
                end
            end
            default: begin
                n_phase = c_phase;
            end
        endcase
        o_group.count = idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_FLAGS;
            r_header   <= 1'b0;
            r_addr     <= 8'd0;
            r_raw      <= 1'b0;
            r_decl     <= 8'd0;
            r_oct_left <= 8'd0;
            r_shift    <= 3'd1;
            r_carry    <= 7'd0;
            r_produced <= 8'd0;
            r_skip     <= 9'd0;
        end else if (i_take) begin
            r_phase    <= n_phase;
            r_header   <= n_header;
            r_addr     <= n_addr;
            r_raw      <= n_raw;
            r_decl     <= n_decl;
            r_oct_left <= n_oct_left;
            r_shift    <= n_shift;
            r_carry    <= n_carry;
            r_produced <= n_produced;
            r_skip     <= n_skip;
        end
    end

endmodule

// ----- design/spsu_result_fifo.sv -----
module spsu_result_fifo
    import spsu_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_result_group i_group,
    output logic          o_room,
    output logic          o_valid,
    input  logic          i_stall,
    output t_result       o_data
);

    t_result          r_mem [RQ_DEPTH];
    logic [RQ_AW-1:0] r_wr_ptr;
    logic [RQ_AW-1:0] r_rd_ptr;
    logic [RQ_AW:0]   r_count;
    logic [1:0]       push_n;
    logic             pop;

    assign push_n  = i_push ? i_group.count : 2'd0;
    assign o_valid = (r_count != '0);
    assign pop     = o_valid && !i_stall;
    assign o_data  = r_mem[r_rd_ptr];
    // room for a worst-case octet without looking at this cycle's pop
    assign o_room  = (r_count <= (RQ_AW+1)'(RQ_DEPTH - MAX_RESULTS));

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_RESULTS; i++) begin
            if (i_push && (2'(i) < i_group.count)) begin
                r_mem[r_wr_ptr + RQ_AW'(i)] <= i_group.items[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + RQ_AW'(push_n);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (RQ_AW+1)'(push_n) - (RQ_AW+1)'(pop);
        end
    end

endmodule

// ----- design/sms_pdu_septet_unpacker_top.sv -----
// SMS PDU septet unpacker. Takes a PDU one octet per item (i_pdu_start marks
// the flags octet of a new PDU and restarts the parser) and reports its parts
// as tagged result items: address length, address digits (low nibble first,
// a trailing 0xF filler dropped), format (1 for 7-bit, else the DCS value),
// message characters and a closing end item carrying the delivered length.
// With DCS zero the user data is unpacked from GSM 7-bit septets; header
// characters are skipped. Octets after the end item yield nothing until the
// next start. Timing: an accepted octet waits in the input register, where it
// is parsed combinationally, and its results enter an 8-entry result queue
// when the octet is taken, once the queue has room; with an empty queue the
// first result shows at the queue output as soon as it is written. An octet can be
// accepted every cycle while the queue holds five or fewer results; the queue
// drains one result per cycle while the output is not stalled, so an octet
// that yields more than one result (each yields 0 to 3) slows the input.
module sms_pdu_septet_unpacker_top
    import spsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_octet,
    input  logic       i_pdu_start,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [2:0] o_kind,
    output logic [7:0] o_value,
    output logic       o_last
);

    // Input register
    logic       r_in_valid;
    logic [7:0] r_octet;
    logic       r_start;

    logic          room;
    logic          take;
    logic          accept;
    t_result_group group;
    t_result       head;

    // Hold the octet while the queue lacks room for its results
    assign take       = r_in_valid && room;
    assign o_in_stall = r_in_valid && !room;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_octet <= i_octet;
            r_start <= i_pdu_start;
        end
    end

    // Parse one octet per cycle while the queue has room, against the running PDU state
    spsu_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_octet     (r_octet),
        .i_pdu_start (r_start),
        .o_group     (group)
    );

    // Queue results and deliver them one per cycle while the output is not stalled
    spsu_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take),
        .i_group (group),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (head)
    );

    assign o_kind  = 3'(head.kind);
    assign o_value = head.value;
    assign o_last  = head.last;

endmodule

// ----- design/spsu_checker.sv -----
module spsu_checker
    import spsu_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [2:0] o_kind,
    input logic [7:0] o_value,
    input logic       o_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            $stable(o_kind) && $stable(o_value) && $stable(o_last))
        else $error("stalled result changed");

    a_last_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last == (o_kind == K_END)))
        else $error("last flag and end tag disagree");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_kind == K_ALEN || o_kind == K_DIGIT || o_kind == K_FMT ||
                         o_kind == K_CHAR || o_kind == K_END))
        else $error("bad result tag");

    a_digit_nibble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == K_DIGIT) |-> (o_value[7:4] == 4'h0))
        else $error("address digit wider than a nibble");

endmodule

bind sms_pdu_septet_unpacker_top spsu_checker u_spsu_checker (.*);
